### sv/fvg_pkg.sv
// Shared constants, codes and types of the FAT volume geometry parser.
package fvg_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int POS_W        = $clog2(SECTOR_BYTES);

  localparam int JOB_DEPTH = 2;
  localparam int JPTR_W    = $clog2(JOB_DEPTH);
  localparam int JCNT_W    = $clog2(JOB_DEPTH + 1);

  localparam logic [1:0] KIND_REQ   = 2'd0;
  localparam logic [1:0] KIND_READY = 2'd1;
  localparam logic [1:0] KIND_FAIL  = 2'd2;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_READ         = 3'd1;
  localparam logic [2:0] ERR_SIGNATURE    = 3'd2;
  localparam logic [2:0] ERR_NOT_BOOT     = 3'd3;
  localparam logic [2:0] ERR_SECTOR_SIZE  = 3'd4;
  localparam logic [2:0] ERR_FAT12        = 3'd5;
  localparam logic [2:0] ERR_ZERO_CLUSTER = 3'd6;

  localparam logic [1:0] FAT_12 = 2'd0;
  localparam logic [1:0] FAT_16 = 2'd1;
  localparam logic [1:0] FAT_32 = 2'd2;

  localparam logic [1:0] OP_FAIL = 2'd0;
  localparam logic [1:0] OP_REQ  = 2'd1;
  localparam logic [1:0] OP_BOOT = 2'd2;

  localparam logic [POS_W-1:0] OFS_MARK_A = POS_W'(54);
  localparam logic [POS_W-1:0] OFS_MARK_B = POS_W'(82);
  localparam logic [POS_W-1:0] OFS_PART   = POS_W'(16'h1c6);
  localparam logic [POS_W-1:0] OFS_SIG0   = POS_W'(SECTOR_BYTES - 2);
  localparam logic [POS_W-1:0] OFS_LAST   = POS_W'(SECTOR_BYTES - 1);

  localparam logic [7:0] SIG0_BYTE = 8'h55;
  localparam logic [7:0] SIG1_BYTE = 8'haa;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_T      = 8'h54;

  localparam logic [15:0] BPS_OK     = 16'h200;
  localparam logic [15:0] CLUS12_MAX = 16'd4095;
  localparam logic [15:0] CLUS16_MAX = 16'd65525;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  err;
    logic [31:0] part;
    logic [7:0]  spc;
    logic [7:0]  nfats;
    logic [15:0] rsv;
    logic [11:0] rds;
    logic [31:0] total;
    logic [31:0] fsz;
    logic [31:0] root_clus;
  } job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [31:0] part;
    logic [1:0]  ftype;
    logic [7:0]  spc;
    logic [31:0] fat_start;
    logic [31:0] data_start;
    logic [31:0] root_start;
    logic [11:0] rds;
    logic [31:0] root_clus;
  } res_t;

  typedef struct packed {
    logic empty;
    logic pop;
  } qctl_t;

endpackage

### sv/fvg_front.sv
// Byte front end: tracks sector position, captures BPB fields, classifies each sector.
module fvg_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic         full,
  input  logic [7:0]   sector_byte,
  input  logic         read_error,
  output logic         job_valid,
  output fvg_pkg::job_t job
);
  import fvg_pkg::*;

  localparam int F_M54 = 0;
  localparam int F_M82 = 1;
  localparam int F_S0  = 2;
  localparam int F_S1  = 3;

  logic [POS_W-1:0] pos;
  logic             boot_phase;
  logic [3:0]       flags;
  logic [3:0]       flags_next;
  logic [31:0]      part_lba;
  logic [15:0]      bps, rsv, rootent, tot16, fsz16;
  logic [7:0]       spc, nfats;
  logic [31:0]      tot32, fsz32, rootclus, pword;

  logic        accept, last, sig, marker;
  logic        phase_next;
  logic [31:0] part_next, boot_part;

  assign accept = push && !full;
  assign last   = (pos == OFS_LAST);

  always_comb begin
    flags_next = flags;
    unique case (pos)
      OFS_MARK_A: begin
        flags_next[F_M54] = (sector_byte == CH_F);
      end
      OFS_MARK_A + POS_W'(1): begin
        if (sector_byte != CH_A) flags_next[F_M54] = 1'b0;
      end
      OFS_MARK_A + POS_W'(2): begin
        if (sector_byte != CH_T) flags_next[F_M54] = 1'b0;
      end
      OFS_MARK_B: begin
        flags_next[F_M82] = (sector_byte == CH_F);
      end
      OFS_MARK_B + POS_W'(1): begin
        if (sector_byte != CH_A) flags_next[F_M82] = 1'b0;
      end
      OFS_MARK_B + POS_W'(2): begin
        if (sector_byte != CH_T) flags_next[F_M82] = 1'b0;
      end
      OFS_SIG0: begin
        flags_next[F_S0] = (sector_byte == SIG0_BYTE);
      end
      OFS_LAST: begin
        flags_next[F_S1] = (sector_byte == SIG1_BYTE);
      end
      default: ;
    endcase
  end

  assign sig       = flags_next[F_S0] && flags_next[F_S1];
  assign marker    = flags_next[F_M54] || flags_next[F_M82];
  assign boot_part = boot_phase ? part_lba : 32'd0;

  always_comb begin
    phase_next = 1'b0;
    part_next  = part_lba;
    if (!boot_phase && sig) begin
      phase_next = !marker;
      part_next  = marker ? 32'd0 : pword;
    end
  end

  always_comb begin
    job           = '0;
    job.part      = boot_part;
    job.spc       = spc;
    job.nfats     = nfats;
    job.rsv       = rsv;
    job.rds       = rootent[15:4];
    job.total     = (tot16 == 16'd0) ? tot32 : {16'd0, tot16};
    job.fsz       = (fsz16 == 16'd0) ? fsz32 : {16'd0, fsz16};
    job.root_clus = rootclus;
    priority if (read_error) begin
      job.op  = OP_FAIL;
      job.err = ERR_READ;
    end else if (!sig) begin
      job.op  = OP_FAIL;
      job.err = boot_phase ? ERR_NOT_BOOT : ERR_SIGNATURE;
    end else if (!marker && boot_phase) begin
      job.op  = OP_FAIL;
      job.err = ERR_NOT_BOOT;
    end else if (!marker) begin
      job      = '0;
      job.op   = OP_REQ;
      job.part = pword;
    end else if (bps != BPS_OK) begin
      job.op  = OP_FAIL;
      job.err = ERR_SECTOR_SIZE;
    end else if (spc == 8'd0) begin
      job.op  = OP_FAIL;
      job.err = ERR_ZERO_CLUSTER;
    end else begin
      job.op  = OP_BOOT;
      job.err = ERR_NONE;
    end
  end

  assign job_valid = accept && (read_error || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      boot_phase <= 1'b0;
      flags      <= '0;
      part_lba   <= '0;
      bps        <= '0;
      rsv        <= '0;
      rootent    <= '0;
      tot16      <= '0;
      fsz16      <= '0;
      spc        <= '0;
      nfats      <= '0;
      tot32      <= '0;
      fsz32      <= '0;
      rootclus   <= '0;
      pword      <= '0;
    end else if (accept) begin
      if (read_error) begin
        pos        <= '0;
        boot_phase <= 1'b0;
      end else begin
        flags <= flags_next;
        unique case (pos)
          POS_W'(11):  bps[7:0]        <= sector_byte;
          POS_W'(12):  bps[15:8]       <= sector_byte;
          POS_W'(13):  spc             <= sector_byte;
          POS_W'(14):  rsv[7:0]        <= sector_byte;
          POS_W'(15):  rsv[15:8]       <= sector_byte;
          POS_W'(16):  nfats           <= sector_byte;
          POS_W'(17):  rootent[7:0]    <= sector_byte;
          POS_W'(18):  rootent[15:8]   <= sector_byte;
          POS_W'(19):  tot16[7:0]      <= sector_byte;
          POS_W'(20):  tot16[15:8]     <= sector_byte;
          POS_W'(22):  fsz16[7:0]      <= sector_byte;
          POS_W'(23):  fsz16[15:8]     <= sector_byte;
          POS_W'(32):  tot32[7:0]      <= sector_byte;
          POS_W'(33):  tot32[15:8]     <= sector_byte;
          POS_W'(34):  tot32[23:16]    <= sector_byte;
          POS_W'(35):  tot32[31:24]    <= sector_byte;
          POS_W'(36):  fsz32[7:0]      <= sector_byte;
          POS_W'(37):  fsz32[15:8]     <= sector_byte;
          POS_W'(38):  fsz32[23:16]    <= sector_byte;
          POS_W'(39):  fsz32[31:24]    <= sector_byte;
          POS_W'(44):  rootclus[7:0]   <= sector_byte;
          POS_W'(45):  rootclus[15:8]  <= sector_byte;
          POS_W'(46):  rootclus[23:16] <= sector_byte;
          POS_W'(47):  rootclus[31:24] <= sector_byte;
          OFS_PART:              pword[7:0]   <= sector_byte;
          OFS_PART + POS_W'(1):  pword[15:8]  <= sector_byte;
          OFS_PART + POS_W'(2):  pword[23:16] <= sector_byte;
          OFS_PART + POS_W'(3):  pword[31:24] <= sector_byte;
          default: ;
        endcase
        if (last) begin
          pos        <= '0;
          boot_phase <= phase_next;
          part_lba   <= part_next;
        end else begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

endmodule

### sv/fvg_queue.sv
// Short job queue between the byte front end and the geometry back end.
module fvg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fvg_pkg::job_t din,
  input  logic          pop,
  output fvg_pkg::job_t head,
  output logic          empty,
  output logic          full
);
  import fvg_pkg::*;

  job_t              mem [JOB_DEPTH];
  logic [JPTR_W-1:0] wptr, rptr;
  logic [JCNT_W-1:0] cnt;
  logic              do_push, do_pop;

  assign empty   = (cnt == JCNT_W'(0));
  assign full    = (cnt == JCNT_W'(JOB_DEPTH));
  assign head    = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) wptr <= (wptr == JPTR_W'(JOB_DEPTH - 1)) ? '0 : wptr + JPTR_W'(1);
      if (do_pop)  rptr <= (rptr == JPTR_W'(JOB_DEPTH - 1)) ? '0 : rptr + JPTR_W'(1);
      if (do_push && !do_pop)      cnt <= cnt + JCNT_W'(1);
      else if (do_pop && !do_push) cnt <= cnt - JCNT_W'(1);
    end
  end

endmodule

### sv/fvg_back.sv
// Geometry back end: multi-step volume arithmetic and the result output register.
module fvg_back (
  input  logic           clk,
  input  logic           rst,
  input  fvg_pkg::job_t  head,
  input  fvg_pkg::qctl_t q_in,
  output logic           q_pop,
  output logic           res_valid,
  output fvg_pkg::res_t  res
);
  import fvg_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]  state;
  job_t        j;
  logic [31:0] fats, rc_m2, fat_start, tmp, data_secs, root16, data_start, rmul;
  logic [23:0] t12, t16;
  logic        is12, is16;
  res_t        pend;
  logic        load;

  assign q_pop = (state == ST_IDLE) && !q_in.empty;
  assign load  = (state == ST_FIN) && (!res_valid || q_in.pop);

  always_comb begin
    pend = '0;
    unique case (j.op)
      OP_FAIL: begin
        pend.kind = KIND_FAIL;
        pend.err  = j.err;
      end
      OP_REQ: begin
        pend.kind = KIND_REQ;
        pend.part = j.part;
      end
      OP_BOOT: begin
        if (is12) begin
          pend.kind = KIND_FAIL;
          pend.err  = ERR_FAT12;
        end else begin
          pend.kind       = KIND_READY;
          pend.err        = ERR_NONE;
          pend.part       = j.part;
          pend.spc        = j.spc;
          pend.fat_start  = fat_start;
          pend.data_start = data_start;
          pend.rds        = j.rds;
          pend.ftype      = is16 ? FAT_16 : FAT_32;
          pend.root_start = is16 ? root16 : rmul + data_start;
          pend.root_clus  = is16 ? 32'd0 : j.root_clus;
        end
      end
      default: pend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (q_pop) j <= head;
      ST_MUL: begin
        fats  <= 32'(j.nfats * j.fsz);
        t12   <= 24'(j.spc) * 24'(CLUS12_MAX);
        t16   <= 24'(j.spc) * 24'(CLUS16_MAX);
        rc_m2 <= j.root_clus - 32'd2;
      end
      ST_SUM: begin
        fat_start <= j.part + 32'(j.rsv);
        tmp       <= j.total - 32'(j.rsv) - 32'(j.rds);
        rmul      <= rc_m2 * 32'(j.spc);
      end
      ST_ADD: begin
        data_secs <= tmp - fats;
        root16    <= fat_start + fats;
      end
      ST_CMP: begin
        data_start <= root16 + 32'(j.rds);
        is12       <= data_secs < 32'(t12);
        is16       <= data_secs < 32'(t16);
      end
      default: ;
    endcase
    if (load) res <= pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (q_pop) state <= (head.op == OP_BOOT) ? ST_MUL : ST_FIN;
        ST_MUL:  state <= ST_SUM;
        ST_SUM:  state <= ST_ADD;
        ST_ADD:  state <= ST_CMP;
        ST_CMP:  state <= ST_FIN;
        ST_FIN:  if (load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (load)          res_valid <= 1'b1;
      else if (q_in.pop) res_valid <= 1'b0;
    end
  end

endmodule

### sv/fat_volume_geometry_parser.sv
// Top level of the FAT volume geometry parser.
// Takes one sector byte per beat, one beat per cycle while full is low; full
// rises only when two jobs (finished sectors or read errors) wait in the job
// queue. A result comes out at the end of each sector (or on a read error):
// only a boot sector takes the multiply, sum, add and compare states; then the
// result sits in the output register until popped. Sector zero is an MBR when
// it lacks the "FAT" marker; a boot-sector read request is then emitted and
// the next sector is parsed as the boot sector of that partition.
module fat_volume_geometry_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  sector_byte,
  input  logic        read_error,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [2:0]  error_code,
  output logic [31:0] partition_start,
  output logic [1:0]  fat_type,
  output logic [7:0]  cluster_sectors,
  output logic [31:0] fat_start_sector,
  output logic [31:0] data_start_sector,
  output logic [31:0] rootdir_start_sector,
  output logic [11:0] root_sector_count,
  output logic [31:0] rootdir_start_cluster
);
  import fvg_pkg::*;

  logic  q_push, q_full, q_empty, q_pop, res_valid;
  job_t  job, head;
  res_t  res;
  qctl_t q_ctl;

  assign full = q_full;

  fvg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (q_full),
    .sector_byte(sector_byte),
    .read_error (read_error),
    .job_valid  (q_push),
    .job        (job)
  );

  fvg_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (job),
    .pop  (q_pop),
    .head (head),
    .empty(q_empty),
    .full (q_full)
  );

  assign q_ctl.empty = q_empty;
  assign q_ctl.pop   = pop;

  fvg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_in     (q_ctl),
    .q_pop    (q_pop),
    .res_valid(res_valid),
    .res      (res)
  );

  assign empty                 = !res_valid;
  assign result_kind           = res.kind;
  assign error_code            = res.err;
  assign partition_start       = res.part;
  assign fat_type              = res.ftype;
  assign cluster_sectors       = res.spc;
  assign fat_start_sector      = res.fat_start;
  assign data_start_sector     = res.data_start;
  assign rootdir_start_sector  = res.root_start;
  assign root_sector_count     = res.rds;
  assign rootdir_start_cluster = res.root_clus;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("job queue written while full");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == KIND_FAIL) |->
      (partition_start == 32'd0 && cluster_sectors == 8'd0 && error_code != ERR_NONE))
    else $error("failed result carries geometry");

  a_ready_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == KIND_READY) |->
      (error_code == ERR_NONE && fat_type != FAT_12 && cluster_sectors != 8'd0))
    else $error("ready result inconsistent");
`endif

endmodule
